### design/pnm_hdr_pkg.sv
// Shared constants, types and helpers of the PNM header parser.
`default_nettype none
package pnm_hdr_pkg;

  localparam int VALUE_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int OUT_W           = 16;
  localparam int BYTE_W          = 8;

  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  // One result beat, as seen on the output channel.
  typedef struct packed {
    logic             header_done;
    logic [OUT_W-1:0] header_length;
    logic [OUT_W-1:0] magic_number;
    logic [OUT_W-1:0] image_width;
    logic [OUT_W-1:0] image_height;
    logic [OUT_W-1:0] max_grey;
    logic             header_filled;
    logic             value_saturated;
  } hdr_result_t;

  function automatic logic is_sep(input logic [BYTE_W-1:0] c);
    is_sep = (c == CH_HASH) || (c == CH_TAB) || (c == CH_SPACE) ||
             (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage
`default_nettype wire

### design/pnm_hdr_if.sv
// Valid/ready stream interfaces for the byte input and the header result.
`default_nettype none
interface pnm_in_if import pnm_hdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface pnm_out_if import pnm_hdr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             header_done;
  logic [OUT_W-1:0] header_length;
  logic [OUT_W-1:0] magic_number;
  logic [OUT_W-1:0] image_width;
  logic [OUT_W-1:0] image_height;
  logic [OUT_W-1:0] max_grey;
  logic             header_filled;
  logic             value_saturated;

  modport source (output valid, output header_done, output header_length,
                  output magic_number, output image_width, output image_height,
                  output max_grey, output header_filled, output value_saturated,
                  input ready);
  modport sink   (input valid, input header_done, input header_length,
                  input magic_number, input image_width, input image_height,
                  input max_grey, input header_filled, input value_saturated,
                  output ready);
endinterface
`default_nettype wire

### design/pnm_header_parser_top.sv
// Top level of the PNM header parser: handshake and result register.
//
// Usage:
//   in_i  carries one file byte per beat (data_byte, start_of_file).
//         Raise start_of_file on the first byte of each file; it clears
//         all header state before that byte is parsed.
//   out_o returns exactly one result beat per input beat, in order: the
//         header fields as they stand after that byte.
// Timing: the parser state and the result register both load on the
//   accepting clock edge, so the result is valid the next cycle.
// Throughput: one byte per cycle unless out_o stalls. The whole per-byte
//   update (separator test, multiply-by-ten accumulate, field commit, byte
//   count) is one short combinational path between the state registers.
// Stall: the result register holds while out_o.ready is low; in_i.ready
//   stays high as long as the result register is empty or being drained
//   in the same cycle, so a sink that keeps ready high sees no bubbles.
// Reset: rst_ni clears all header state and the result valid.
`default_nettype none
module pnm_header_parser_top import pnm_hdr_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pnm_in_if.sink     in_i,
  pnm_out_if.source  out_o
);

  logic        accept;
  logic        out_valid_q, out_valid_d;
  hdr_result_t result_next;
  hdr_result_t result_q;

  // take a beat when the result slot is free or draining now
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  pnm_hdr_core #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (accept),
    .data_byte_i (in_i.data_byte),
    .sof_i       (in_i.start_of_file),
    .result_o    (result_next)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_next;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.header_done     = result_q.header_done;
  assign out_o.header_length   = result_q.header_length;
  assign out_o.magic_number    = result_q.magic_number;
  assign out_o.image_width     = result_q.image_width;
  assign out_o.image_height    = result_q.image_height;
  assign out_o.max_grey        = result_q.max_grey;
  assign out_o.header_filled   = result_q.header_filled;
  assign out_o.value_saturated = result_q.value_saturated;

  a_beat_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted beat produced no result");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("input taken while result stalled");

  a_drain_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_o.ready && !accept |=> !out_valid_q)
    else $error("result repeated after drain");

endmodule
`default_nettype wire

### design/pnm_hdr_core.sv
// Header state registers and the per-byte update logic.
`default_nettype none
module pnm_hdr_core import pnm_hdr_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic [BYTE_W-1:0] data_byte_i,
  input  wire logic              sof_i,
  output hdr_result_t            result_o
);

  localparam int AW = VALUE_WIDTH + 4;
  localparam logic [VALUE_WIDTH-1:0] VAL_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [VALUE_WIDTH-1:0] VAL_ONE = VALUE_WIDTH'(1);

  logic [VALUE_WIDTH-1:0] magic_q, magic_d, width_q, width_d;
  logic [VALUE_WIDTH-1:0] height_q, height_d, maxg_q, maxg_d;
  logic [VALUE_WIDTH-1:0] accum_q, accum_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   incmt_q, incmt_d, filled_q, filled_d;
  logic                   done_q, done_d, ovf_q, ovf_d;

  logic [AW-1:0] prod;
  logic [3:0]    digit;

  always_comb begin
    // start of file clears everything before the byte is handled
    magic_d  = sof_i ? '0 : magic_q;
    width_d  = sof_i ? '0 : width_q;
    height_d = sof_i ? '0 : height_q;
    maxg_d   = sof_i ? '0 : maxg_q;
    accum_d  = sof_i ? '0 : accum_q;
    cnt_d    = sof_i ? '0 : cnt_q;
    incmt_d  = sof_i ? 1'b0 : incmt_q;
    filled_d = sof_i ? 1'b0 : filled_q;
    done_d   = sof_i ? 1'b0 : done_q;
    ovf_d    = sof_i ? 1'b0 : ovf_q;

    digit = 4'(data_byte_i - CH_ZERO);
    prod  = (AW'(accum_d) << 3) + (AW'(accum_d) << 1) + AW'(digit);

    if (!done_d) begin
      if (is_sep(data_byte_i)) begin
        // commit to the next empty field
        if (!incmt_d && (accum_d != '0)) begin
          if (magic_d == '0) begin
            magic_d = accum_d;
          end else if (width_d == '0) begin
            width_d = accum_d;
          end else if (height_d == '0) begin
            height_d = accum_d;
            filled_d = (magic_d == VAL_ONE);
          end else if (maxg_d == '0) begin
            maxg_d   = accum_d;
            filled_d = (magic_d > VAL_ONE);
          end
        end
        if ((data_byte_i == CH_LF) || (data_byte_i == CH_TAB)) begin
          incmt_d = 1'b0;
        end else if (data_byte_i == CH_HASH) begin
          incmt_d = 1'b1;
        end
        accum_d = '0;
        if (cnt_d == CNT_MAX) begin
          ovf_d = 1'b1;
        end else begin
          cnt_d = cnt_d + COUNT_WIDTH'(1);
        end
      end else if (!incmt_d && filled_d) begin
        done_d = 1'b1;
      end else begin
        if (!incmt_d && is_digit(data_byte_i)) begin
          if (|prod[AW-1:VALUE_WIDTH]) begin
            accum_d = VAL_MAX;
            ovf_d   = 1'b1;
          end else begin
            accum_d = prod[VALUE_WIDTH-1:0];
          end
        end
        if (cnt_d == CNT_MAX) begin
          ovf_d = 1'b1;
        end else begin
          cnt_d = cnt_d + COUNT_WIDTH'(1);
        end
      end
    end
  end

  always_comb begin
    result_o.header_done     = done_d;
    result_o.header_length   = OUT_W'(cnt_d);
    result_o.magic_number    = OUT_W'(magic_d);
    result_o.image_width     = OUT_W'(width_d);
    result_o.image_height    = OUT_W'(height_d);
    result_o.max_grey        = OUT_W'(maxg_d);
    result_o.header_filled   = filled_d;
    result_o.value_saturated = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q  <= '0;
      width_q  <= '0;
      height_q <= '0;
      maxg_q   <= '0;
      accum_q  <= '0;
      cnt_q    <= '0;
      incmt_q  <= 1'b0;
      filled_q <= 1'b0;
      done_q   <= 1'b0;
      ovf_q    <= 1'b0;
    end else if (en_i) begin
      magic_q  <= magic_d;
      width_q  <= width_d;
      height_q <= height_d;
      maxg_q   <= maxg_d;
      accum_q  <= accum_d;
      cnt_q    <= cnt_d;
      incmt_q  <= incmt_d;
      filled_q <= filled_d;
      done_q   <= done_d;
      ovf_q    <= ovf_d;
    end
  end

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !(en_i && sof_i) |=> done_q)
    else $error("header done dropped without start of file");

  a_frozen_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && en_i && !sof_i |=> $stable(cnt_q) && $stable(maxg_q))
    else $error("state moved after header end");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(cnt_q) && $stable(accum_q) && $stable(incmt_q))
    else $error("state moved without a beat");

  a_filled_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q |-> (magic_q != '0) && (width_q != '0) && (height_q != '0))
    else $error("filled set with an empty field");

endmodule
`default_nettype wire

### sim/pnm_hdr_checker.sv
// Scoreboard for the PNM header parser: tracks the header state per byte beat and checks results.
module pnm_hdr_checker import pnm_hdr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pnm_in_if         in_mon,
  pnm_out_if        out_mon,
  output int        err_cnt_o,
  output int        pending_o
);

  logic [15:0] magic_q, width_q, height_q, maxval_q, accum_q, count_q;
  logic        comment_q, filled_q, done_q, sat_q;

  hdr_result_t header_q[$];

  function automatic void clear_header();
    magic_q   = '0;
    width_q   = '0;
    height_q  = '0;
    maxval_q  = '0;
    accum_q   = '0;
    count_q   = '0;
    comment_q = 1'b0;
    filled_q  = 1'b0;
    done_q    = 1'b0;
    sat_q     = 1'b0;
  endfunction

  // Header state after one byte; returns the fields as the parser shows them.
  function automatic hdr_result_t parse_byte(logic [7:0] c, logic sof);
    hdr_result_t r;
    logic [19:0] next_acc;
    logic        counted;
    counted = 1'b0;
    if (sof) clear_header();
    if (!done_q) begin
      if (c == CH_HASH || c == CH_TAB || c == CH_SPACE || c == CH_CR || c == CH_LF) begin
        // commit to the first empty field
        if (!comment_q && accum_q != 0) begin
          if (magic_q == 0) begin
            magic_q = accum_q;
          end else if (width_q == 0) begin
            width_q = accum_q;
          end else if (height_q == 0) begin
            height_q = accum_q;
            filled_q = (magic_q == 1);
          end else if (maxval_q == 0) begin
            maxval_q = accum_q;
            filled_q = (magic_q > 1);
          end
        end
        if (c == CH_LF || c == CH_TAB) comment_q = 1'b0;
        else if (c == CH_HASH) comment_q = 1'b1;
        accum_q = '0;
        counted = 1'b1;
      end else if (!comment_q && filled_q) begin
        done_q = 1'b1;
      end else begin
        if (!comment_q && c >= CH_ZERO && c <= CH_NINE) begin
          next_acc = 20'(accum_q) * 20'd10 + 20'(c - CH_ZERO);
          if (next_acc > 20'hFFFF) begin
            accum_q = 16'hFFFF;
            sat_q   = 1'b1;
          end else begin
            accum_q = next_acc[15:0];
          end
        end
        counted = 1'b1;
      end
      if (counted) begin
        if (count_q == 16'hFFFF) sat_q = 1'b1;
        else count_q = count_q + 16'd1;
      end
    end
    r.header_done     = done_q;
    r.header_length   = count_q;
    r.magic_number    = magic_q;
    r.image_width     = width_q;
    r.image_height    = height_q;
    r.max_grey        = maxval_q;
    r.header_filled   = filled_q;
    r.value_saturated = sat_q;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      err_cnt_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hdr_result_t want;
    if (!rst_ni) begin
      clear_header();
      header_q.delete();
      err_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (header_q.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, actual len %0d magic %0d",
                   $time, out_mon.header_length, out_mon.magic_number);
          err_cnt_o++;
        end else begin
          want = header_q.pop_front();
          check_field("header_done", want.header_done, out_mon.header_done);
          check_field("header_length", want.header_length, out_mon.header_length);
          check_field("magic_number", want.magic_number, out_mon.magic_number);
          check_field("image_width", want.image_width, out_mon.image_width);
          check_field("image_height", want.image_height, out_mon.image_height);
          check_field("max_grey", want.max_grey, out_mon.max_grey);
          check_field("header_filled", want.header_filled, out_mon.header_filled);
          check_field("value_saturated", want.value_saturated, out_mon.value_saturated);
        end
      end
      if (in_mon.valid && in_mon.ready)
        header_q.push_back(parse_byte(in_mon.data_byte, in_mon.start_of_file));
      pending_o = header_q.size();
    end
  end

endmodule

### sim/tb_top.sv
// Testbench top for the PNM header parser: byte stimulus, result stalls, watchdog and verdict.
module tb_top;
  import pnm_hdr_pkg::*;

  localparam int N_ITEMS     = 1850;
  localparam int STALL_LIMIT = 4000;   // cycles with no beat on either side
  localparam int HOLD_CYCLES = 60;     // long receiver hold-off

  logic clk;
  logic rst_n;

  int send_idle;     // percent of cycles the sender idles before a beat
  int recv_idle;     // percent of cycles the receiver drops ready
  int hold_reqs;     // long hold-offs asked for by the stimulus
  int holds_done;    // long hold-offs carried out by the receiver
  int quiet_cycles;
  int err_cnt;
  int pending;

  logic [7:0] file_q[$];  // bytes of the file being sent
  bit         file_sof;   // raise start_of_file on its first byte

  pnm_in_if  in_bus ();
  pnm_out_if out_bus ();

  pnm_header_parser_top u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  pnm_hdr_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_mon    (in_bus),
    .out_mon   (out_bus),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // File builders
  // ---------------------------------------------------------------------------

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
  endfunction

  // Mostly small header values; sometimes zero (never committed), the
  // 16-bit maximum, or something past it to make the accumulator saturate.
  function automatic int unsigned rand_value();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(65536, 999999);
      3, 4, 5: return $urandom_range(1, 9);
      default: return $urandom_range(1, 2000);
    endcase
  endfunction

  // Decimal digits, now and then with a leading zero or a stray non-digit
  // in the middle (stray characters are skipped, so "1x2" reads as 12).
  function automatic void push_num(int unsigned v);
    logic [7:0] digits[$];
    logic [7:0] c;
    do begin
      digits.push_front(8'(v % 10) + CH_ZERO);
      v = v / 10;
    end while (v != 0);
    if ($urandom_range(9) == 0) digits.push_front(CH_ZERO);
    if (digits.size() > 1 && $urandom_range(9) == 0) begin
      do c = 8'($urandom_range(255));
      while (c == CH_HASH || c == CH_TAB || c == CH_SPACE || c == CH_CR || c == CH_LF ||
             (c >= CH_ZERO && c <= CH_NINE));
      digits.insert($urandom_range(1, digits.size() - 1), c);
    end
    foreach (digits[i]) file_q.push_back(digits[i]);
  endfunction

  // Whitespace run between tokens, sometimes with a comment closed by LF or tab.
  function automatic void push_gap();
    logic [7:0] c;
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 9))
        1: file_q.push_back(CH_TAB);
        2: file_q.push_back(CH_CR);
        3: file_q.push_back(CH_LF);
        4: begin
          file_q.push_back(CH_HASH);
          repeat ($urandom_range(0, 8)) begin
            do c = 8'($urandom_range(255)); while (c == CH_TAB || c == CH_LF);
            file_q.push_back(c);
          end
          file_q.push_back($urandom_range(1) ? CH_LF : CH_TAB);
        end
        default: file_q.push_back(CH_SPACE);
      endcase
    end
  endfunction

  // Builds one random file into file_q. Most are well-formed headers with a
  // few data bytes behind them; some are cut short, some are plain noise.
  // Returns how many of the bytes the parser actually looks at.
  function automatic int build_file();
    int kind;
    int unsigned magic;
    int cut;
    int live;
    file_q.delete();
    kind = $urandom_range(0, 19);
    if (kind < 3) begin
      // noise, possibly continuing whatever header came before
      file_sof = $urandom_range(1);
      repeat ($urandom_range(5, 30)) begin
        case ($urandom_range(0, 3))
          0:       file_q.push_back(CH_ZERO + 8'($urandom_range(9)));
          1:       file_q.push_back($urandom_range(1) ? CH_SPACE : CH_HASH);
          2:       file_q.push_back($urandom_range(1) ? CH_LF : CH_TAB);
          default: file_q.push_back(8'($urandom_range(255)));
        endcase
      end
      return file_q.size();
    end
    file_sof = 1'b1;
    magic = ($urandom_range(4) != 0) ? $urandom_range(1, 6) : rand_value();
    if ($urandom_range(9) != 0) push_text("P");
    push_num(magic);
    push_gap();
    push_num(rand_value());
    push_gap();
    push_num(rand_value());
    // P1 has no max grey; once in a while give it one anyway
    if (magic != 1 || $urandom_range(7) == 0) begin
      push_gap();
      push_num(rand_value());
    end
    push_gap();
    if (kind < 6) begin
      // truncated header, the next file restarts the parser
      cut = $urandom_range(1, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
      return file_q.size();
    end
    // first data byte ends the header, the rest are ignored
    live = file_q.size() + 1;
    repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom_range(255)));
    return live;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------

  // One byte beat. Valid drops only on idle cycles, so back-to-back beats
  // keep it high without a low/high pair in the same time step.
  task automatic send_beat(logic [7:0] b, logic sof);
    while ($urandom_range(99) < send_idle) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.data_byte     <= b;
    in_bus.start_of_file <= sof;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_beat(file_q[i], file_sof && i == 0);
  endtask

  task automatic run_phase(int s_idle, int r_idle, int n_items);
    int sent;
    send_idle = s_idle;
    recv_idle = r_idle;
    sent = 0;
    while (sent < n_items) begin
      sent += build_file();
      send_file();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, plus a long hold-off on request. During the
  // hold-off the sender keeps offering, so the result register fills and
  // in_i.ready must drop.
  // ---------------------------------------------------------------------------
  initial begin
    out_bus.ready = 1'b0;
    holds_done    = 0;
    wait (rst_n);
    forever begin
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle);
      end
      @(posedge clk);
    end
  end

  // Watchdog: any beat on either channel resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and verdict
  // ---------------------------------------------------------------------------
  initial begin
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.data_byte     = '0;
    in_bus.start_of_file = 1'b0;
    send_idle            = 0;
    recv_idle            = 0;
    hold_reqs            = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: width at the 16-bit maximum, comment holding a second '#'
    // and closed by LF, CR as separator, max grey, header end, and a byte
    // after the end that must change nothing.
    file_q.delete();
    push_text("P5 65535#a#\n1\r255 Dq");
    file_sof = 1'b1;
    send_file();

    // Directed: P1 needs no max grey; oversized width saturates the
    // accumulator; a 0xFF stray inside the height is skipped ("1?2" = 12);
    // tab ends the token; a digit after a filled header ends it; 0x00
    // after the end is ignored.
    file_q.delete();
    push_text("P1 99999 1");
    file_q.push_back(8'hFF);
    push_text("2\t7");
    file_q.push_back(8'h00);
    send_file();

    // Random files under the three idling mixes; the long hold-off lands
    // at the start of the last mix, where the sender never idles.
    run_phase(12, 85, N_ITEMS / 3);
    run_phase(85, 12, N_ITEMS / 3);
    hold_reqs++;
    run_phase(0, 0, N_ITEMS - 2 * (N_ITEMS / 3));
    in_bus.valid <= 1'b0;

    // drain, then let the registered result settle
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (err_cnt == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
